FILE: rtl/gscc_pkg.sv
// Shared constants, codes and position tables of the gear shift command controller.
`default_nettype none

package gscc_pkg;

    localparam int GEAR_COUNT_DEF = 14;

    localparam int GEAR_W   = 4;
    localparam int LEVEL_W  = 6;
    localparam int POS_W    = 11;
    localparam int SPEED_W  = 5;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESEND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UP_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd6;

    // command bytes
    localparam logic [7:0] RX_ACK      = 8'hC2;
    localparam logic [7:0] RX_CAL_DONE = 8'hC3;
    localparam logic [7:0] CMD_MOVE    = 8'h41;
    localparam logic [7:0] CMD_CAL_FIN = 8'h44;
    localparam logic [7:0] FRAME_TAIL  = 8'hDF;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    // reset values
    localparam logic [COUNT_W-1:0] HOLDOFF_RST = 16'd50000;
    localparam logic [COUNT_W-1:0] RESEND_RST  = 16'd10000;
    localparam logic [LEVEL_W-1:0] DOWN_LOW_RST  = 6'd18;
    localparam logic [LEVEL_W-1:0] DOWN_HIGH_RST = 6'd22;
    localparam logic [LEVEL_W-1:0] UP_LOW_RST    = 6'd40;
    localparam logic [LEVEL_W-1:0] UP_HIGH_RST   = 6'd44;
    localparam logic [LEVEL_W-1:0] RELEASE_RST   = 6'd63;
    localparam logic [POS_W-1:0]   POS_RST       = 11'd1256;
    localparam logic [SPEED_W-1:0] SPEED_RST     = 5'd26;

    // calibration request and finish settings
    localparam logic [POS_W-1:0]   POS_CAL_REQ   = 11'd1900;
    localparam logic [SPEED_W-1:0] SPEED_CAL_REQ = 5'd15;
    localparam logic [POS_W-1:0]   POS_CAL_FIN   = 11'd1885;
    localparam logic [SPEED_W-1:0] SPEED_CAL_FIN = 5'd31;

    function automatic logic [POS_W-1:0] up_pos(input logic [GEAR_W-1:0] idx);
        logic [POS_W-1:0] p;
        case (idx)
            4'd0:    p = 11'd160;
            4'd1:    p = 11'd292;
            4'd2:    p = 11'd424;
            4'd3:    p = 11'd556;
            4'd4:    p = 11'd688;
            4'd5:    p = 11'd820;
            4'd6:    p = 11'd952;
            4'd7:    p = 11'd1084;
            4'd8:    p = 11'd1216;
            4'd9:    p = 11'd1348;
            4'd10:   p = 11'd1480;
            4'd11:   p = 11'd1612;
            4'd12:   p = 11'd1744;
            default: p = 11'd1856;
        endcase
        return p;
    endfunction

    function automatic logic [POS_W-1:0] down_pos(input logic [GEAR_W-1:0] idx);
        logic [POS_W-1:0] p;
        case (idx)
            4'd0:    p = 11'd120;
            4'd1:    p = 11'd232;
            4'd2:    p = 11'd364;
            4'd3:    p = 11'd496;
            4'd4:    p = 11'd628;
            4'd5:    p = 11'd760;
            4'd6:    p = 11'd892;
            4'd7:    p = 11'd1024;
            4'd8:    p = 11'd1156;
            4'd9:    p = 11'd1288;
            4'd10:   p = 11'd1420;
            4'd11:   p = 11'd1552;
            4'd12:   p = 11'd1684;
            default: p = 11'd1816;
        endcase
        return p;
    endfunction

    // CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gear_shift_command_controller_top.sv
// Gear shift command controller: button judging, gear tracking and command frames.
//
// Channel  Dir   Handshake            Payload
// s_       in    s_tvalid/s_tready    s_tuser kind, s_tdata levels and received frame
// m_       out   m_tvalid/m_tready    m_tdata command frame and gear index
// cfg_     in    cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// One item per cycle while s_tready is high: the whole item is judged by the decode logic
// feeding the state and result registers, so a result appears in the cycle after its transfer.
// The result register frees s_tready whenever it is empty or being taken.
// aresetn is synchronous and active low; the control and configuration registers load their reset values.
// cfg_ready is always high; writes take effect on the next cycle.
`default_nettype none

module gear_shift_command_controller_top #(
    parameter int GEAR_COUNT = gscc_pkg::GEAR_COUNT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [5:0] level_a, [11:6] level_b, [17:12] level_c, [25:18] rx_byte0,
    // [33:26] rx_byte1, [41:34] rx_byte2, [49:42] rx_byte3, rest zero
    input  wire logic [gscc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  wire logic [gscc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] frame_cmd, [15:8] frame_hi, [23:16] frame_lo, [31:24] frame_tail,
    // [35:32] gear_now, rest zero
    output logic [gscc_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gscc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gscc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [gscc_pkg::GEAR_W-1:0] GearMax = gscc_pkg::GEAR_W'(GEAR_COUNT - 1);

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_DOWN = 2'd2,
        MODE_UP   = 2'd3
    } mode_t;

    // configuration
    logic [gscc_pkg::COUNT_W-1:0] holdoff_ticks_reg, resend_ticks_reg;
    logic [gscc_pkg::LEVEL_W-1:0] down_low_reg, down_high_reg;
    logic [gscc_pkg::LEVEL_W-1:0] up_low_reg, up_high_reg, release_reg;

    // state
    mode_t                        mode_reg, mode_next;
    logic [gscc_pkg::GEAR_W-1:0]  gear_reg, gear_next;
    logic [gscc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [gscc_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic                         awaiting_reg, awaiting_next;
    logic                         resend_active_reg, resend_active_next;
    logic [gscc_pkg::COUNT_W-1:0] resend_cnt_reg, resend_cnt_next;
    logic [gscc_pkg::COUNT_W-1:0] holdoff_cnt_reg, holdoff_cnt_next;

    // result register
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   cmd_reg, cmd_next;
    logic [7:0]                   hi_reg, hi_next;
    logic [7:0]                   lo_reg, lo_next;
    logic [gscc_pkg::GEAR_W-1:0]  gear_out_reg, gear_out_next;

    // unpacked input fields
    logic [1:0]                   kind;
    logic [gscc_pkg::LEVEL_W-1:0] level_a, level_b, level_c;
    logic [7:0]                   rx_byte0, rx_byte1, rx_byte2, rx_byte3;

    logic                         s_xfer, emit;
    logic [gscc_pkg::COUNT_W-1:0] resend_inc;
    logic                         gate_open, levels_eq, crc_ok;
    logic [7:0]                   crc;

    assign kind     = s_tuser[1:0];
    assign level_a  = s_tdata[5:0];
    assign level_b  = s_tdata[11:6];
    assign level_c  = s_tdata[17:12];
    assign rx_byte0 = s_tdata[25:18];
    assign rx_byte1 = s_tdata[33:26];
    assign rx_byte2 = s_tdata[41:34];
    assign rx_byte3 = s_tdata[49:42];

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, gear_out_reg, gscc_pkg::FRAME_TAIL, lo_reg, hi_reg, cmd_reg};

    assign gate_open  = holdoff_cnt_reg >= holdoff_ticks_reg;
    assign levels_eq  = (level_a == level_b) && (level_a == level_c);
    assign resend_inc = (resend_cnt_reg != '1) ? resend_cnt_reg + 1'b1 : resend_cnt_reg;
    assign crc = gscc_pkg::crc8_byte(gscc_pkg::crc8_byte(gscc_pkg::crc8_byte(8'd0, rx_byte2),
                                                         rx_byte1), rx_byte0);
    assign crc_ok = crc == rx_byte3;

    always_comb begin
        mode_next          = mode_reg;
        gear_next          = gear_reg;
        pos_next           = pos_reg;
        speed_next         = speed_reg;
        awaiting_next      = awaiting_reg;
        resend_active_next = resend_active_reg;
        resend_cnt_next    = resend_cnt_reg;
        holdoff_cnt_next   = holdoff_cnt_reg;
        emit               = 1'b0;
        cmd_next           = gscc_pkg::CMD_MOVE;

        case (kind)
            gscc_pkg::KIND_TICK: begin
                if (!gate_open) begin
                    holdoff_cnt_next = holdoff_cnt_reg + 1'b1;
                end
                if (resend_active_reg) begin
                    resend_cnt_next = resend_inc;
                    if (resend_inc > resend_ticks_reg) begin
                        resend_cnt_next = gscc_pkg::COUNT_W'(1);
                        if (awaiting_reg) begin
                            emit = 1'b1;
                        end else begin
                            resend_active_next = 1'b0;
                        end
                    end
                end
            end
            gscc_pkg::KIND_SAMPLE: begin
                if (gate_open && levels_eq) begin
                    case (mode_reg)
                        MODE_WAIT: begin
                            if (level_a > down_low_reg && level_a < down_high_reg) begin
                                mode_next        = MODE_DOWN;
                                holdoff_cnt_next = '0;
                                if (gear_reg != '0) begin
                                    gear_next          = gear_reg - 1'b1;
                                    pos_next           = gscc_pkg::down_pos(gear_reg - 1'b1);
                                    emit               = 1'b1;
                                    awaiting_next      = 1'b1;
                                    resend_cnt_next    = '0;
                                    resend_active_next = 1'b1;
                                end
                            end else if (level_a > up_low_reg && level_a < up_high_reg) begin
                                mode_next        = MODE_UP;
                                holdoff_cnt_next = '0;
                                if (gear_reg < GearMax) begin
                                    gear_next          = gear_reg + 1'b1;
                                    pos_next           = gscc_pkg::up_pos(gear_reg + 1'b1);
                                    emit               = 1'b1;
                                    awaiting_next      = 1'b1;
                                    resend_cnt_next    = '0;
                                    resend_active_next = 1'b1;
                                end
                            end
                        end
                        MODE_DOWN, MODE_UP: begin
                            if (level_a == release_reg) begin
                                mode_next        = MODE_WAIT;
                                holdoff_cnt_next = '0;
                            end
                        end
                        default: begin
                            // init: any pressed level asks for calibration
                            if (level_a > down_low_reg && level_a < up_high_reg) begin
                                pos_next         = gscc_pkg::POS_CAL_REQ;
                                speed_next       = gscc_pkg::SPEED_CAL_REQ;
                                emit             = 1'b1;
                                holdoff_cnt_next = '0;
                            end
                        end
                    endcase
                end
            end
            gscc_pkg::KIND_FRAME: begin
                if (crc_ok) begin
                    if (rx_byte0 == gscc_pkg::RX_ACK) begin
                        awaiting_next = 1'b0;
                    end
                    if (mode_reg == MODE_INIT && rx_byte0 == gscc_pkg::RX_CAL_DONE) begin
                        speed_next = gscc_pkg::SPEED_CAL_FIN;
                        pos_next   = gscc_pkg::POS_CAL_FIN;
                        gear_next  = GearMax;
                        mode_next  = MODE_WAIT;
                        emit       = 1'b1;
                        cmd_next   = gscc_pkg::CMD_CAL_FIN;
                    end
                end
            end
            default: begin
            end
        endcase

        hi_next       = {speed_next, pos_next[10:8]};
        lo_next       = pos_next[7:0];
        gear_out_next = gear_next;

        if (s_xfer) begin
            m_valid_next = emit;
        end else begin
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holdoff_ticks_reg <= gscc_pkg::HOLDOFF_RST;
            resend_ticks_reg  <= gscc_pkg::RESEND_RST;
            down_low_reg      <= gscc_pkg::DOWN_LOW_RST;
            down_high_reg     <= gscc_pkg::DOWN_HIGH_RST;
            up_low_reg        <= gscc_pkg::UP_LOW_RST;
            up_high_reg       <= gscc_pkg::UP_HIGH_RST;
            release_reg       <= gscc_pkg::RELEASE_RST;
            mode_reg          <= MODE_INIT;
            gear_reg          <= '0;
            pos_reg           <= gscc_pkg::POS_RST;
            speed_reg         <= gscc_pkg::SPEED_RST;
            awaiting_reg      <= 1'b0;
            resend_active_reg <= 1'b0;
            resend_cnt_reg    <= '0;
            holdoff_cnt_reg   <= gscc_pkg::HOLDOFF_RST;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gscc_pkg::REG_HOLDOFF:   holdoff_ticks_reg <= cfg_data;
                    gscc_pkg::REG_RESEND:    resend_ticks_reg  <= cfg_data;
                    gscc_pkg::REG_DOWN_LOW:  down_low_reg      <= cfg_data[5:0];
                    gscc_pkg::REG_DOWN_HIGH: down_high_reg     <= cfg_data[5:0];
                    gscc_pkg::REG_UP_LOW:    up_low_reg        <= cfg_data[5:0];
                    gscc_pkg::REG_UP_HIGH:   up_high_reg       <= cfg_data[5:0];
                    gscc_pkg::REG_RELEASE:   release_reg       <= cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if (s_xfer) begin
                mode_reg          <= mode_next;
                gear_reg          <= gear_next;
                pos_reg           <= pos_next;
                speed_reg         <= speed_next;
                awaiting_reg      <= awaiting_next;
                resend_active_reg <= resend_active_next;
                resend_cnt_reg    <= resend_cnt_next;
                holdoff_cnt_reg   <= holdoff_cnt_next;
            end
            m_valid_reg <= m_valid_next;
        end
        // payload loads with the transfer, no reset needed
        if (s_xfer) begin
            cmd_reg      <= cmd_next;
            hi_reg       <= hi_next;
            lo_reg       <= lo_next;
            gear_out_reg <= gear_out_next;
        end
    end

`ifndef SYNTHESIS
    a_gear_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gear_reg <= GearMax)
        else $error("gear index beyond last gear");

    a_init_gear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_INIT) |-> (gear_reg == '0))
        else $error("gear moved before calibration finished");

    a_cal_leaves_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && cmd_reg == gscc_pkg::CMD_CAL_FIN) |-> (mode_reg != MODE_INIT))
        else $error("calibration finish sent while still in init mode");

    a_ack_has_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        awaiting_reg |-> resend_active_reg)
        else $error("unacknowledged command without a running resend timer");
`endif

endmodule

`default_nettype wire
